@@ hdl/pphb_pkg.sv @@
// Shared types and constants for the banded PI position-hold controller.
// Used by pphb_core and pi_position_hold_banded; no dependencies.
`timescale 1ns / 1ps

package pphb_pkg;

  localparam int SampleBits = 12;
  localparam int SumBits    = 24;
  localparam int DriveBits  = 8;
  localparam int GainBits   = 10;
  localparam int CapBits    = 7;
  localparam int BandBits   = 12;
  localparam int CfgIdxBits = 4;
  localparam int CfgDataBits = 12;

  typedef enum logic [CfgIdxBits-1:0] {
    RegPropGain  = 4'd0,
    RegIntegGain = 4'd1,
    RegIntegCap  = 4'd2,
    RegDriveCap  = 4'd3,
    RegDeadBand  = 4'd4,
    RegDownBand  = 4'd5,
    RegUpBand    = 4'd6,
    RegCreep     = 4'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GainBits-1:0] prop_gain;
    logic [GainBits-1:0] integ_gain;
    logic [BandBits-1:0] integ_cap;
    logic [CapBits-1:0]  drive_cap;
    logic [BandBits-1:0] dead_band;
    logic [BandBits-1:0] down_band;
    logic [BandBits-1:0] up_band;
    logic [CapBits-1:0]  creep_drive;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:   10'd90,
    integ_gain:  10'd13,
    integ_cap:   12'd30,
    drive_cap:   7'd127,
    dead_band:   12'd30,
    down_band:   12'd500,
    up_band:     12'd200,
    creep_drive: 7'd30
  };

endpackage

@@ hdl/pphb_core.sv @@
// Control-law datapath: error, saturating integral, PI sum and drive shaping.
// Purely combinational; depends on pphb_pkg.
`timescale 1ns / 1ps

module pphb_core import pphb_pkg::*; (
  input  cfg_t                        cfg_i,
  input  logic [SampleBits-1:0]       setpoint_i,
  input  logic [SampleBits-1:0]       position_i,
  input  logic signed [SumBits-1:0]   error_sum_i,
  output logic signed [SumBits-1:0]   error_sum_o,
  output logic signed [DriveBits-1:0] drive_o
);

  logic signed [SampleBits:0]   err;
  logic [SampleBits:0]          aerr_w;
  logic [BandBits-1:0]          aerr;
  logic signed [SumBits:0]      sum_w;
  logic signed [SumBits-1:0]    sum_sat;
  logic signed [SumBits:0]      sum_x;
  logic signed [SumBits:0]      icap_x;
  logic signed [SumBits:0]      ic_w;
  logic signed [BandBits:0]     ic;
  logic signed [GainBits+SampleBits+1:0] prod_p;
  logic signed [GainBits+BandBits+1:0]   prod_i;
  logic signed [24:0]           raw;
  logic signed [24:0]           raw_adj;
  logic signed [16:0]           pi;
  logic [16:0]                  pi_mag;
  logic                         pi_neg;
  logic                         pi_pos;
  logic signed [DriveBits-1:0]  dcap_s;
  logic signed [DriveBits-1:0]  creep_s;

  always_comb begin
    err    = $signed({1'b0, setpoint_i}) - $signed({1'b0, position_i});
    aerr_w = err[SampleBits] ? 13'(-err) : 13'(err);
    aerr   = aerr_w[BandBits-1:0];

    // Saturating integral: overflow shows as disagreeing top bits
    sum_w = $signed({error_sum_i[SumBits-1], error_sum_i})
          + $signed({{(SumBits-SampleBits){err[SampleBits]}}, err});
    if (sum_w[SumBits] != sum_w[SumBits-1]) begin
      sum_sat = sum_w[SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                               : {1'b0, {(SumBits-1){1'b1}}};
    end else begin
      sum_sat = sum_w[SumBits-1:0];
    end

    // Clamp the integral to +/- integ_cap for the I term
    sum_x  = $signed({sum_sat[SumBits-1], sum_sat});
    icap_x = $signed({{(SumBits+1-BandBits){1'b0}}, cfg_i.integ_cap});
    if (!sum_sat[SumBits-1]) begin
      ic_w = (sum_x < icap_x) ? sum_x : icap_x;
    end else begin
      ic_w = (sum_x > -icap_x) ? sum_x : -icap_x;
    end
    ic = ic_w[BandBits:0];

    prod_p  = $signed({1'b0, cfg_i.prop_gain}) * err;
    prod_i  = $signed({1'b0, cfg_i.integ_gain}) * ic;
    raw     = 25'(prod_p) + 25'(prod_i);
    // Truncate toward zero: bias negative values before the shift
    raw_adj = raw[24] ? raw + 25'sd255 : raw;
    pi      = raw_adj[24:8];
    pi_neg  = pi[16];
    pi_pos  = !pi[16] && (pi != '0);
    pi_mag  = pi_neg ? 17'(-pi) : 17'(pi);

    dcap_s  = $signed({1'b0, cfg_i.drive_cap});
    creep_s = $signed({1'b0, cfg_i.creep_drive});

    if (aerr < cfg_i.dead_band) begin
      drive_o = '0;
    end else if (aerr < cfg_i.down_band && pi_neg) begin
      drive_o = -creep_s;
    end else if (aerr < cfg_i.up_band && pi_pos) begin
      drive_o = creep_s;
    end else if (pi_mag > 17'(cfg_i.drive_cap)) begin
      drive_o = pi_neg ? -dcap_s : dcap_s;
    end else begin
      drive_o = pi[DriveBits-1:0];
    end

    error_sum_o = sum_sat;
  end

endmodule

@@ hdl/pi_position_hold_banded.sv @@
// Top level of the banded PI position-hold controller: stream ports, config
// registers, input and result registers. Depends on pphb_pkg and pphb_core.
`timescale 1ns / 1ps

// One result per sample transfer. A sample is registered in the input
// register, then the whole control law (error, integral update, two gain
// multiplies, shaping) runs combinationally into the result register, and a
// new sample is taken every cycle while the result side drains. The integral
// is updated as a sample moves into the result register.
// Config writes are always ready and should only be issued while idle.
module pi_position_hold_banded import pphb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // [11:0] setpoint, [23:12] position
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // [7:0] left_drive, [15:8] right_drive
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  cfg_t                        cfg_q;
  logic                        in_valid_q;
  logic [SampleBits-1:0]       setpoint_q;
  logic [SampleBits-1:0]       position_q;
  logic                        out_valid_q;
  logic signed [DriveBits-1:0] left_q;
  logic signed [DriveBits-1:0] right_q;
  logic signed [SumBits-1:0]   error_sum_q;
  logic signed [SumBits-1:0]   error_sum_d;
  logic signed [DriveBits-1:0] drive_d;
  logic                        out_free;
  logic                        advance;
  logic                        in_take;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {right_q, left_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPropGain:  cfg_q.prop_gain   <= cfg_data_i[GainBits-1:0];
        RegIntegGain: cfg_q.integ_gain  <= cfg_data_i[GainBits-1:0];
        RegIntegCap:  cfg_q.integ_cap   <= cfg_data_i[BandBits-1:0];
        RegDriveCap:  cfg_q.drive_cap   <= cfg_data_i[CapBits-1:0];
        RegDeadBand:  cfg_q.dead_band   <= cfg_data_i[BandBits-1:0];
        RegDownBand:  cfg_q.down_band   <= cfg_data_i[BandBits-1:0];
        RegUpBand:    cfg_q.up_band     <= cfg_data_i[BandBits-1:0];
        RegCreep:     cfg_q.creep_drive <= cfg_data_i[CapBits-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      error_sum_q <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        error_sum_q <= error_sum_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      setpoint_q <= s_axis_tdata[SampleBits-1:0];
      position_q <= s_axis_tdata[2*SampleBits-1:SampleBits];
    end
    if (advance) begin
      left_q  <= drive_d;
      right_q <= -drive_d;
    end
  end

  pphb_core u_core (
    .cfg_i       (cfg_q),
    .setpoint_i  (setpoint_q),
    .position_i  (position_q),
    .error_sum_i (error_sum_q),
    .error_sum_o (error_sum_d),
    .drive_o     (drive_d)
  );

  // The two motor outputs always mirror each other
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (right_q == -left_q))
    else $error("right drive is not the negation of left drive");

  // The integral moves only when a sample passes into the result register
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(error_sum_q))
    else $error("integral changed without a sample advancing");

  // A result appears only from a sample that advanced
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result valid rose without an advancing sample");

endmodule

@@ sim/pi_position_hold_banded_tb.sv @@
// Self-checking testbench for pi_position_hold_banded: drives sample and config
// transfers, predicts each drive pair and checks every result in order.
// Depends on pphb_pkg and the RTL of pi_position_hold_banded.
`timescale 1ns / 1ps

module pi_position_hold_banded_tb;
  import pphb_pkg::*;

  localparam int HalfPeriod    = 2;
  localparam int ResetCycles   = 12;
  localparam int SettleCycles  = 4;
  localparam int MaxReports    = 10;
  localparam int StallCycles   = 64;
  localparam int SwingItems    = 50;
  // Longest quiet stretch of a good run is the receiver hold-off plus a few
  // random gaps; allow many times that.
  localparam int WatchdogLimit = 4000;

  localparam longint SumMax = (longint'(1) << (SumBits - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  localparam logic [SampleBits-1:0] SampleMax      = '1;
  localparam logic [SampleBits-1:0] SampleZero     = '0;
  localparam logic [CfgIdxBits-1:0] RegFirstUnused = 4'd8;
  localparam logic [CfgIdxBits-1:0] RegLastUnused  = 4'd15;

  typedef struct packed {
    logic signed [DriveBits-1:0] right;
    logic signed [DriveBits-1:0] left;
  } drive_t;

  typedef enum int {
    ShapeDead,
    ShapeDown,
    ShapeUp,
    ShapeCap,
    ShapeLinear
  } shape_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata  = '0;  // [11:0] setpoint, [23:12] position
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [15:0]            m_axis_tdata;        // [7:0] left_drive, [15:8] right_drive
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i   = '0;
  logic [CfgDataBits-1:0] cfg_data_i    = '0;

  cfg_t   hold_cfg  = CfgReset;
  longint integ_sum = 0;
  drive_t drive_q[$];

  int mismatches     = 0;
  int results_seen   = 0;
  int samples_sent   = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_req      = 0;
  int stall_left     = 0;
  int shape_hits[5]  = '{default: 0};

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  pi_position_hold_banded u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Advance the integral and shape the drive for one accepted sample.
  function automatic drive_t predict_drive(logic [SampleBits-1:0] sp,
                                           logic [SampleBits-1:0] pos);
    longint err, aerr, asum, icap, ic, raw, pi, cap, drive;
    shape_e shape;
    drive_t d;
    err = longint'(sp) - longint'(pos);
    aerr = (err < 0) ? -err : err;
    integ_sum += err;
    if (integ_sum > SumMax) integ_sum = SumMax;
    if (integ_sum < SumMin) integ_sum = SumMin;
    asum = (integ_sum < 0) ? -integ_sum : integ_sum;
    icap = longint'(hold_cfg.integ_cap);
    if (asum < icap) ic = integ_sum;
    else ic = (integ_sum < 0) ? -icap : icap;
    raw = longint'(hold_cfg.prop_gain) * err + longint'(hold_cfg.integ_gain) * ic;
    pi = raw / 256;  // truncates toward zero
    cap = longint'(hold_cfg.drive_cap);
    if (aerr < longint'(hold_cfg.dead_band)) begin
      drive = 0;
      shape = ShapeDead;
    end else if (aerr < longint'(hold_cfg.down_band) && pi < 0) begin
      drive = -longint'(hold_cfg.creep_drive);
      shape = ShapeDown;
    end else if (aerr < longint'(hold_cfg.up_band) && pi > 0) begin
      drive = longint'(hold_cfg.creep_drive);
      shape = ShapeUp;
    end else if (((pi < 0) ? -pi : pi) > cap) begin
      drive = (pi < 0) ? -cap : cap;
      shape = ShapeCap;
    end else begin
      drive = pi;
      shape = ShapeLinear;
    end
    shape_hits[shape]++;
    d.left  = DriveBits'(drive);
    d.right = DriveBits'(-drive);
    return d;
  endfunction

  // Fill the bits above the register width with noise; the block must drop them.
  function automatic logic [CfgDataBits-1:0] with_noise(logic [CfgDataBits-1:0] v, int w);
    logic [CfgDataBits-1:0] m;
    m = CfgDataBits'((1 << w) - 1);
    return (v & m) | (CfgDataBits'($urandom) & ~m);
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.prop_gain   = GainBits'($urandom_range(1023));
    c.integ_gain  = GainBits'($urandom_range(1023));
    c.integ_cap   = BandBits'($urandom_range(1) ? $urandom_range(200) : $urandom_range(4095));
    c.drive_cap   = CapBits'($urandom_range(127));
    c.dead_band   = BandBits'($urandom_range(100));
    c.down_band   = BandBits'($urandom_range(1) ? $urandom_range(800) : $urandom_range(4095));
    c.up_band     = BandBits'($urandom_range(1) ? $urandom_range(800) : $urandom_range(4095));
    c.creep_drive = CapBits'($urandom_range(127));
    return c;
  endfunction

  task automatic send_sample(input logic [SampleBits-1:0] sp, input logic [SampleBits-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    drive_q.push_back(predict_drive(sp, pos));
    samples_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegPropGain:  hold_cfg.prop_gain   = val[GainBits-1:0];
      RegIntegGain: hold_cfg.integ_gain  = val[GainBits-1:0];
      RegIntegCap:  hold_cfg.integ_cap   = val[BandBits-1:0];
      RegDriveCap:  hold_cfg.drive_cap   = val[CapBits-1:0];
      RegDeadBand:  hold_cfg.dead_band   = val[BandBits-1:0];
      RegDownBand:  hold_cfg.down_band   = val[BandBits-1:0];
      RegUpBand:    hold_cfg.up_band     = val[BandBits-1:0];
      RegCreep:     hold_cfg.creep_drive = val[CapBits-1:0];
      default: ;  // unused index: drop
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input cfg_t c);
    wait_drain();
    write_reg(RegPropGain,  with_noise(CfgDataBits'(c.prop_gain),   GainBits));
    write_reg(RegIntegGain, with_noise(CfgDataBits'(c.integ_gain),  GainBits));
    write_reg(RegIntegCap,  with_noise(CfgDataBits'(c.integ_cap),   BandBits));
    write_reg(RegDriveCap,  with_noise(CfgDataBits'(c.drive_cap),   CapBits));
    write_reg(RegDeadBand,  with_noise(CfgDataBits'(c.dead_band),   BandBits));
    write_reg(RegDownBand,  with_noise(CfgDataBits'(c.down_band),   BandBits));
    write_reg(RegUpBand,    with_noise(CfgDataBits'(c.up_band),     BandBits));
    write_reg(RegCreep,     with_noise(CfgDataBits'(c.creep_drive), CapBits));
  endtask

  // Half the samples sit within a few bands of the setpoint, half anywhere.
  task automatic send_random_batch(input int n);
    int i, step, tgt;
    logic [SampleBits-1:0] sp, pos;
    for (i = 0; i < n; i++) begin
      sp = SampleBits'($urandom_range(4095));
      if ($urandom_range(1)) begin
        pos = SampleBits'($urandom_range(4095));
      end else begin
        step = $urandom_range(1400) - 700;
        tgt = int'(sp) - step;
        if (tgt < 0) tgt = 0;
        if (tgt > int'(SampleMax)) tgt = int'(SampleMax);
        pos = SampleBits'(tgt);
      end
      send_sample(sp, pos);
    end
    end_burst();
  endtask

  // Reset settings: input extremes and the edges of each band.
  task automatic test_directed();
    send_sample(SampleZero, SampleZero);
    send_sample(SampleMax, SampleZero);
    send_sample(SampleZero, SampleMax);
    send_sample(SampleMax, SampleMax);
    send_sample(12'd2000, 12'd1971);  // just inside dead band
    send_sample(12'd2000, 12'd1970);  // on dead band edge
    send_sample(12'd1971, 12'd2000);
    send_sample(12'd1970, 12'd2000);
    send_sample(12'd2000, 12'd2100);  // down creep
    send_sample(12'd2000, 12'd2499);
    send_sample(12'd2000, 12'd2500);  // past down band
    send_sample(12'd2100, 12'd2000);  // up creep
    send_sample(12'd2199, 12'd2000);
    send_sample(12'd2200, 12'd2000);  // past up band
    send_sample(12'd2300, 12'd2000);
    send_sample(12'd1000, 12'd3000);  // large error, capped
    send_sample(12'd3000, 12'd1000);
    send_sample(12'h555, 12'hAAA);
    send_sample(12'hAAA, 12'h555);
    end_burst();
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    apply_setting('0);
    send_random_batch(8);
    c = CfgReset;
    c.integ_cap = '0;
    c.drive_cap = '0;
    apply_setting(c);
    send_random_batch(12);
    apply_setting('1);
    send_random_batch(8);
    apply_setting(CfgReset);
  endtask

  task automatic test_unused_index();
    wait_drain();
    write_reg(RegFirstUnused, CfgDataBits'($urandom));
    write_reg(RegLastUnused, CfgDataBits'($urandom));
    write_reg(CfgIdxBits'($urandom_range(RegLastUnused, RegFirstUnused)), CfgDataBits'($urandom));
    send_random_batch(16);
  endtask

  task automatic test_random_phases();
    int phase, k;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 33; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (k = 0; k < 4; k++) begin
        apply_setting(random_setting());
        send_random_batch(40);
      end
    end
  endtask

  // Hold the result side while samples keep coming, drain, then a 25%-idle batch.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drain();
    stall_req = StallCycles;
    send_random_batch(80);
    wait_drain();
    recv_idle_pct = 25;
    send_random_batch(20);
  endtask

  // Swing the integral far to both sides. With only the integral sign feeding
  // the drive, a wrong sign or a lost update shows up at once.
  task automatic test_integral_swing();
    cfg_t c;
    int i;
    c = '0;
    c.integ_gain = '1;
    c.integ_cap  = 12'd1;
    c.drive_cap  = '1;
    send_idle_pct = 0;
    recv_idle_pct = 10;
    apply_setting(c);
    for (i = 0; i < SwingItems; i++) send_sample(SampleMax, SampleZero);
    for (i = 0; i < 2 * SwingItems; i++) send_sample(SampleZero, SampleMax);
    while (integ_sum < 0) send_sample(SampleMax, SampleZero);
    end_burst();
    send_random_batch(10);
  endtask

  task automatic finish_run();
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);
    mismatches += drive_q.size();
    $display("Checked %0d drive pairs from %0d samples over random gains, caps and bands",
             results_seen, samples_sent);
    $display("Shaping seen: dead %0d, down creep %0d, up creep %0d, capped %0d, linear %0d;",
             shape_hits[ShapeDead], shape_hits[ShapeDown], shape_hits[ShapeUp],
             shape_hits[ShapeCap], shape_hits[ShapeLinear]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  endtask

  // Result side readiness, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    drive_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result %h with no sample pending", $realtime, m_axis_tdata);
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata[7:0] !== want.left || m_axis_tdata[15:8] !== want.right) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result %0d left exp %0d got %0d, right exp %0d got %0d",
                     $realtime, results_seen, want.left, $signed(m_axis_tdata[7:0]),
                     want.right, $signed(m_axis_tdata[15:8]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_register_extremes();
    test_unused_index();
    test_random_phases();
    test_backpressure();
    test_integral_swing();
    finish_run();
  end

endmodule
